@@ rtl/core/signed_integer_to_decimal_ascii_defines.svh @@
// Assertion macros shared by the decimal printer RTL.
// Each macro expects a clock named i_clk and an active-low reset named i_rst_n.
`ifndef SIGNED_INTEGER_TO_DECIMAL_ASCII_DEFINES_SVH
`define SIGNED_INTEGER_TO_DECIMAL_ASCII_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SIDA_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("sida: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define SIDA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("sida: next-cycle check failed");

`endif

@@ rtl/core/sida_pkg.sv @@
package sida_pkg;

    // One BCD digit and one output character code.
    typedef logic [3:0] t_digit;
    typedef logic [5:0] t_char;

    localparam int unsigned RADIX = 10;

    localparam t_char CHAR_MINUS  = 6'd45;
    localparam t_char CHAR_DIGIT0 = 6'd48;

    // Shift-and-add-3: a digit of five or more gets three added before it doubles.
    localparam t_digit DABBLE_THRESH = t_digit'(RADIX / 2);
    localparam t_digit DABBLE_ADD    = t_digit'((16 - RADIX) / 2);

endpackage

@@ rtl/core/sida_bcd_step.sv @@
module sida_bcd_step #(
    parameter int NUM_DIGITS = 19
) (
    input  sida_pkg::t_digit [NUM_DIGITS-1:0] i_digits,
    input  logic                              i_carry,
    output sida_pkg::t_digit [NUM_DIGITS-1:0] o_digits
);
    import sida_pkg::*;

    t_digit [NUM_DIGITS-1:0] w_adj;

    // One double dabble step: correct every digit, then shift the whole
    // BCD word left by one bit with the next magnitude bit entering at the bottom.
    always_comb begin
        for (int d = 0; d < NUM_DIGITS; d++) begin
            if (i_digits[d] >= DABBLE_THRESH) begin
                w_adj[d] = i_digits[d] + DABBLE_ADD;
            end else begin
                w_adj[d] = i_digits[d];
            end
        end
        o_digits[0] = {w_adj[0][2:0], i_carry};
        for (int d = 1; d < NUM_DIGITS; d++) begin
            o_digits[d] = {w_adj[d][2:0], w_adj[d-1][3]};
        end
    end

endmodule

@@ rtl/core/signed_integer_to_decimal_ascii.sv @@
// Channel  | Direction | Signals                       | Handshake
// ---------+-----------+-------------------------------+-----------------------------------
// number   | in        | i_number                      | transfer when start && !busy
// text     | out       | o_character, o_last           | transfer on every o_strobe cycle
//
// Each number passes the shared double dabble step, which consumes one
// magnitude bit per cycle, then a sign state when it is negative, then
// the character stage, which walks every BCD digit slot once (leading
// zeros are dropped without a strobe). Reset is synchronous and active
// low; it returns the sequencer to idle and clears the strobe. The
// receiver cannot stall: every character is shown for exactly one cycle.

`include "signed_integer_to_decimal_ascii_defines.svh"

module signed_integer_to_decimal_ascii #(
    parameter int VALUE_WIDTH = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [63:0]          i_number,
    output logic                 o_strobe,
    output sida_pkg::t_char      o_character,
    output logic                 o_last
);
    import sida_pkg::*;

    // Number of decimal digits in the largest magnitude, 2**(VALUE_WIDTH-1).
    // 1233/4096 is a close lower bound of log10(2).
    localparam int DIGITS = ((VALUE_WIDTH - 1) * 1233) / 4096 + 1;
    localparam int CNT_W  = $clog2(VALUE_WIDTH);
    localparam int LEFT_W = $clog2(DIGITS + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CONV = 2'd1;
    localparam logic [1:0] S_SIGN = 2'd2;
    localparam logic [1:0] S_EMIT = 2'd3;

    // Control state.
    logic [1:0]        r_state, n_state;
    logic [CNT_W-1:0]  r_bit_cnt, n_bit_cnt;
    logic [LEFT_W-1:0] r_left, n_left;
    logic              r_started, n_started;
    logic              r_neg, n_neg;
    logic              r_strobe, n_strobe;

    // Payload.
    logic [VALUE_WIDTH-1:0]  r_mag, n_mag;
    t_digit [DIGITS-1:0]     r_digits, n_digits;
    t_char                   r_char, n_char;
    logic                    r_last, n_last;

    logic [VALUE_WIDTH-1:0]  w_raw;
    logic [VALUE_WIDTH-1:0]  w_abs;
    t_digit [DIGITS-1:0]     w_step;
    t_digit                  w_top;
    logic                    w_skip;

    assign w_raw = i_number[VALUE_WIDTH-1:0];
    // The most negative value negates to itself, which read unsigned is its
    // exact magnitude.
    assign w_abs = w_raw[VALUE_WIDTH-1] ? (~w_raw + VALUE_WIDTH'(1)) : w_raw;

    sida_bcd_step #(
        .NUM_DIGITS (DIGITS)
    ) u_step (
        .i_digits (r_digits),
        .i_carry  (r_mag[VALUE_WIDTH-1]),
        .o_digits (w_step)
    );

    assign w_top = r_digits[DIGITS-1];
    // A zero in the top slot before the first printed digit is a leading zero,
    // except in the ones slot, so that zero itself prints as a single '0'.
    assign w_skip = !r_started && (w_top == '0) && (r_left != LEFT_W'(1));

    always_comb begin
        n_state   = r_state;
        n_bit_cnt = r_bit_cnt;
        n_left    = r_left;
        n_started = r_started;
        n_neg     = r_neg;
        n_strobe  = 1'b0;
        n_mag     = r_mag;
        n_digits  = r_digits;
        n_char    = r_char;
        n_last    = r_last;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state   = S_CONV;
                    n_mag     = w_abs;
                    n_neg     = w_raw[VALUE_WIDTH-1];
                    n_digits  = '0;
                    n_bit_cnt = CNT_W'(VALUE_WIDTH - 1);
                end
            end
            S_CONV: begin
                // One magnitude bit per cycle enters the BCD word.
                n_digits  = w_step;
                n_mag     = {r_mag[VALUE_WIDTH-2:0], 1'b0};
                n_bit_cnt = r_bit_cnt - CNT_W'(1);
                if (r_bit_cnt == '0) begin
                    n_state   = r_neg ? S_SIGN : S_EMIT;
                    n_left    = LEFT_W'(DIGITS);
                    n_started = 1'b0;
                end
            end
            S_SIGN: begin
                n_strobe = 1'b1;
                n_char   = CHAR_MINUS;
                n_last   = 1'b0;
                n_state  = S_EMIT;
            end
            S_EMIT: begin
                // The digit word moves up one slot per cycle; the top slot is
                // either printed or dropped as a leading zero.
                for (int d = DIGITS - 1; d > 0; d--) begin
                    n_digits[d] = r_digits[d-1];
                end
                n_digits[0] = '0;
                n_left      = r_left - LEFT_W'(1);
                if (!w_skip) begin
                    n_strobe  = 1'b1;
                    n_started = 1'b1;
                    n_char    = CHAR_DIGIT0 + {2'b00, w_top};
                    n_last    = (r_left == LEFT_W'(1));
                end
                if (r_left == LEFT_W'(1)) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_bit_cnt <= '0;
            r_left    <= '0;
            r_started <= 1'b0;
            r_neg     <= 1'b0;
            r_strobe  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_bit_cnt <= n_bit_cnt;
            r_left    <= n_left;
            r_started <= n_started;
            r_neg     <= n_neg;
            r_strobe  <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mag    <= n_mag;
        r_digits <= n_digits;
        r_char   <= n_char;
        r_last   <= n_last;
    end

    assign busy        = (r_state != S_IDLE);
    assign o_strobe    = r_strobe;
    assign o_character = r_char;
    assign o_last      = r_last;

    // A character that does not close its run means more characters follow.
    `SIDA_ASSERT_SAME(a_run_continues, o_strobe && !o_last, busy)
    // The minus sign never ends a run.
    `SIDA_ASSERT_SAME(a_sign_not_last, o_strobe && (o_character == CHAR_MINUS), !o_last)
    // A new number starts conversion and produces no character right away.
    `SIDA_ASSERT_NEXT(a_start_conv, start && !busy, (r_state == S_CONV) && !o_strobe)
    // The character stage always has digit slots left to walk.
    `SIDA_ASSERT_SAME(a_emit_left, r_state == S_EMIT, r_left != '0)

endmodule

@@ tb/sv/decimal_text_checker.sv @@
// Watches the number and text channels of the decimal printer, predicts the
// character run of every accepted number and compares each strobed character
// against the oldest prediction.
module decimal_text_checker (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    input  logic             busy,
    input  logic [63:0]      i_number,
    input  logic             o_strobe,
    input  sida_pkg::t_char  o_character,
    input  logic             o_last,
    output int               o_failures,
    output int               o_awaited
);
    import sida_pkg::*;

    typedef struct packed {
        t_char character;
        logic  last;
    } t_text_char;

    t_text_char awaited_text[$];
    int         failures = 0;

    // Queues the characters that print one number: a minus sign when it is
    // negative, then the digits of the magnitude, most significant first, with the final one flagged.
    function automatic void spell_decimal(input logic [63:0] value);
        logic [63:0] magnitude;
        t_digit      digits [20];
        int          count;
        begin
            // The most negative value wraps onto itself, which read unsigned
            // is exactly its magnitude.
            magnitude = value[63] ? (~value + 64'd1) : value;
            count     = 0;
            do begin
                digits[count] = t_digit'(magnitude % RADIX);
                magnitude     = magnitude / RADIX;
                count++;
            end while (magnitude != 64'd0);
            if (value[63]) begin
                awaited_text.push_back('{character: CHAR_MINUS, last: 1'b0});
            end
            for (int i = count - 1; i >= 0; i--) begin
                awaited_text.push_back('{character: CHAR_DIGIT0 + t_char'(digits[i]),
                                         last: (i == 0)});
            end
        end
    endfunction

    always @(posedge i_clk) begin
        t_text_char due;
        if (i_rst_n) begin
            if (o_strobe) begin
                if (awaited_text.size() == 0) begin
                    $error("unexpected character: character expected none actual %0d",
                           o_character);
                    failures++;
                end else begin
                    due = awaited_text.pop_front();
                    if (o_character !== due.character) begin
                        $error("character mismatch: expected %0d actual %0d",
                               due.character, o_character);
                        failures++;
                    end
                    if (o_last !== due.last) begin
                        $error("last mismatch: expected %0d actual %0d", due.last, o_last);
                        failures++;
                    end
                end
            end
            if (start && !busy) begin
                spell_decimal(i_number);
            end
        end
        o_failures <= failures;
        o_awaited  <= awaited_text.size();
    end

endmodule

@@ tb/sv/signed_integer_to_decimal_ascii_test.sv @@
// Top of the decimal printer test. It makes the stimulus and gives the
// verdict; the checker beside the block does all prediction and comparison.
module signed_integer_to_decimal_ascii_test;
    import sida_pkg::*;

    localparam int DIRECTED_COUNT = 20;
    localparam int RANDOM_COUNT   = 160;
    localparam int TOTAL_COUNT    = DIRECTED_COUNT + RANDOM_COUNT;
    // Items near the end of the run go back to back, with no idle gaps.
    localparam int CALM_TAIL      = 30;
    // The tail wait after the last character is longer than the block needs
    // for one whole number.
    localparam int SETTLE_CYCLES  = 100;

    // Boundary values: zero, one digit, the changes in digit count at powers
    // of ten, the 32-bit edges, alternating bit patterns, the largest value,
    // its negation and the most negative value, which yields twenty characters.
    localparam logic [63:0] DIRECTED_NUMBERS [DIRECTED_COUNT] = '{
        64'd0,
        64'd1,
        -64'd1,
        64'd9,
        -64'd9,
        64'd10,
        -64'd10,
        64'd99,
        -64'd100,
        64'd12345,
        64'd999999999999999999,
        64'd1000000000000000000,
        -64'd1000000000000000000,
        64'h7FFF_FFFF_FFFF_FFFF,
        64'h8000_0000_0000_0001,
        64'h8000_0000_0000_0000,
        64'h5555_5555_5555_5555,
        64'hAAAA_AAAA_AAAA_AAAA,
        64'd4294967295,
        -64'd4294967296
    };

    logic            i_clk    = 1'b0;
    logic            i_rst_n  = 1'b0;
    logic            start    = 1'b0;
    logic [63:0]     i_number = 64'd0;
    logic            busy;
    logic            o_strobe;
    t_char           o_character;
    logic            o_last;
    int              failures;
    int              awaited;

    signed_integer_to_decimal_ascii dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_number    (i_number),
        .o_strobe    (o_strobe),
        .o_character (o_character),
        .o_last      (o_last)
    );

    decimal_text_checker text_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_number    (i_number),
        .o_strobe    (o_strobe),
        .o_character (o_character),
        .o_last      (o_last),
        .o_failures  (failures),
        .o_awaited   (awaited)
    );

    // Four time units per clock period.
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Picks a number whose digit count is spread evenly. A plain 64-bit draw
    // almost always has 18 or 19 digits, so most draws shift a random value
    // right by a random amount. Others sit right next to a power of ten,
    // where the digit count changes, and a few are fully random so that
    // every input bit is toggled.
    function automatic logic [63:0] pick_random_number();
        logic [63:0] magnitude;
        int          mode;
        begin
            mode = $urandom_range(0, 9);
            if (mode < 2) begin
                magnitude = {$urandom, $urandom};
            end else if (mode < 8) begin
                magnitude = {$urandom, $urandom} >> $urandom_range(0, 63);
            end else begin
                magnitude = 64'd1;
                repeat ($urandom_range(0, 18)) magnitude = magnitude * 64'd10;
                magnitude = magnitude + 64'd1 - 64'($urandom_range(0, 2));
            end
            if (mode >= 2 && $urandom_range(0, 1) == 1) begin
                magnitude = ~magnitude + 64'd1;
            end
            pick_random_number = magnitude;
        end
    endfunction

    // Offers one number and returns at the edge that completes its transfer.
    // An idle gap or a drain lowers start first. With a drain, the sender
    // holds off until the checker has seen every awaited character, which
    // lets the block run completely dry between two numbers. When neither
    // applies, start simply stays high into the next number.
    task automatic send_number(input logic [63:0] value, input int gap, input bit drain);
        begin
            if (gap > 0 || drain) begin
                start <= 1'b0;
                if (drain) begin
                    do @(posedge i_clk); while (awaited != 0);
                end
                repeat (gap) @(posedge i_clk);
            end
            i_number <= value;
            start    <= 1'b1;
            do @(posedge i_clk); while (busy);
        end
    endtask

    initial begin
        logic [63:0] value;
        int          gap;
        bit          drain;

        // Synchronous reset is held from time zero, then released once.
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int idx = 0; idx < TOTAL_COUNT; idx++) begin
            value = (idx < DIRECTED_COUNT) ? DIRECTED_NUMBERS[idx] : pick_random_number();
            gap   = 0;
            if (idx < TOTAL_COUNT - CALM_TAIL && $urandom_range(0, 3) == 0) begin
                gap = $urandom_range(1, 6);
            end
            drain = (idx == DIRECTED_COUNT + 40 || idx == DIRECTED_COUNT + 100);
            send_number(value, gap, drain);
        end
        start <= 1'b0;

        // Wait for every awaited character, then give the block time to show
        // any stray strobe before the verdict.
        do @(posedge i_clk); while (awaited != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (failures == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // Roughly 180 numbers, with their gaps and drains, stay far below
    // this bound; reaching it means the block has hung.
    initial begin
        #2000000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
